FILE: src/gmc_pkg.sv
`timescale 1ns / 1ps

package gmc_pkg;

  localparam int RAMP_TICKS  = 50;
  localparam int RATIO_LIMIT = 20;

  localparam int TIMER_W   = 6;
  localparam int RATIO_W   = 5;
  localparam int CNT_W     = 8;
  localparam int POS_Q_W   = 11;
  localparam int FORCE_Q_W = 17;

  localparam logic [15:0] RST_POS_CPM   = 16'd10056;
  localparam logic [9:0]  RST_FORCE_CPK = 10'd100;
  localparam logic [7:0]  RST_POS_MIN   = 8'd27;
  localparam logic [7:0]  RST_POS_MAX   = 8'd180;
  localparam logic [7:0]  RST_FORCE_OFS = 8'd7;
  localparam logic [7:0]  RST_FORCE_THR = 8'd15;
  localparam logic [7:0]  RST_MAX_FORCE = 8'd255;
  localparam logic [4:0]  RST_JOG       = 5'd15;

  typedef enum logic [2:0] {
    REG_POS_CPM,
    REG_FORCE_CPK,
    REG_POS_MIN,
    REG_POS_MAX,
    REG_FORCE_OFS,
    REG_FORCE_THR,
    REG_MAX_FORCE,
    REG_JOG
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NEG,
    ST_BAD_POS,
    ST_BUSY
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ARMED,
    PH_MOVING
  } phase_t;

  typedef struct packed {
    logic [15:0]        pos_cpm;
    logic [9:0]         force_cpk;
    logic [CNT_W-1:0]   pos_min;
    logic [CNT_W-1:0]   pos_max;
    logic [CNT_W-1:0]   force_ofs;
    logic [CNT_W-1:0]   force_thr;
    logic [CNT_W-1:0]   max_force;
    logic [RATIO_W-1:0] jog;
  } cfg_t;

  typedef struct packed {
    logic                 command;
    logic                 negative;
    logic [POS_Q_W-1:0]   pos_q;
    logic [FORCE_Q_W-1:0] force_q;
    logic [CNT_W-1:0]     force_smp;
    logic [CNT_W-1:0]     pos_smp;
  } s1_t;

endpackage

FILE: src/gmc_ifs.sv
`timescale 1ns / 1ps

interface gmc_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [11:0] target_mm;
  logic signed [15:0] target_kg;
  logic [7:0]         force_sample;
  logic [7:0]         position_sample;

  modport source (output valid, command, target_mm, target_kg, force_sample,
                  position_sample, input ready);
  modport sink (input valid, command, target_mm, target_kg, force_sample,
                position_sample, output ready);
endinterface

interface gmc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] motor_ratio;
  logic       direction_in;
  logic       busy_res;
  logic [1:0] status;
  logic       done_res;

  modport source (output valid, motor_ratio, direction_in, busy_res, status, done_res,
                  input ready);
  modport sink (input valid, motor_ratio, direction_in, busy_res, status, done_res,
                output ready);
endinterface

interface gmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/gmc_regs.sv
`timescale 1ns / 1ps

module gmc_regs
  import gmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gmc_cfg_if.sink    cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg         = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_cpm   <= RST_POS_CPM;
      cfg_r.force_cpk <= RST_FORCE_CPK;
      cfg_r.pos_min   <= RST_POS_MIN;
      cfg_r.pos_max   <= RST_POS_MAX;
      cfg_r.force_ofs <= RST_FORCE_OFS;
      cfg_r.force_thr <= RST_FORCE_THR;
      cfg_r.max_force <= RST_MAX_FORCE;
      cfg_r.jog       <= RST_JOG;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_POS_CPM:   cfg_r.pos_cpm   <= cfg_ch.data;
        REG_FORCE_CPK: cfg_r.force_cpk <= cfg_ch.data[9:0];
        REG_POS_MIN:   cfg_r.pos_min   <= cfg_ch.data[CNT_W-1:0];
        REG_POS_MAX:   cfg_r.pos_max   <= cfg_ch.data[CNT_W-1:0];
        REG_FORCE_OFS: cfg_r.force_ofs <= cfg_ch.data[CNT_W-1:0];
        REG_FORCE_THR: cfg_r.force_thr <= cfg_ch.data[CNT_W-1:0];
        REG_MAX_FORCE: cfg_r.max_force <= cfg_ch.data[CNT_W-1:0];
        REG_JOG:       cfg_r.jog       <= cfg_ch.data[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/gmc_scale.sv
`timescale 1ns / 1ps

module gmc_scale
  import gmc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  gmc_in_if.sink  in_ch,
  input  cfg_t    cfg,
  input  logic    adv,
  output logic    s1_valid,
  output s1_t     s1
);

  logic        s1_valid_r;
  s1_t         s1_r;
  s1_t         s1_nxt;
  logic [26:0] pos_prod;
  logic [24:0] force_prod;
  logic        take;

  // sign bits are checked separately, so only magnitude bits enter the multipliers
  assign pos_prod   = 27'(in_ch.target_mm[10:0]) * 27'(cfg.pos_cpm);
  assign force_prod = 25'(in_ch.target_kg[14:0]) * 25'(cfg.force_cpk);

  assign in_ch.ready = !s1_valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_nxt.command   = in_ch.command;
    s1_nxt.negative  = in_ch.target_mm[11] || in_ch.target_kg[15];
    s1_nxt.pos_q     = pos_prod[26:16];
    s1_nxt.force_q   = force_prod[24:8];
    s1_nxt.force_smp = in_ch.force_sample;
    s1_nxt.pos_smp   = in_ch.position_sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

FILE: src/gmc_ctrl.sv
`timescale 1ns / 1ps

module gmc_ctrl
  import gmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s1_valid,
  input  s1_t       s1,
  input  cfg_t      cfg,
  output logic      adv,
  gmc_out_if.source out_ch
);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   goal_pos_r, goal_pos_nxt;
  logic [CNT_W-1:0]   goal_force_r, goal_force_nxt;
  logic [RATIO_W-1:0] boost_r, boost_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [CNT_W-1:0]   last_pos_r, last_pos_nxt;
  logic [CNT_W-1:0]   last_force_r, last_force_nxt;
  logic               dir_r, dir_nxt;

  logic               out_valid_r;
  logic [RATIO_W-1:0] ratio_r, ratio_nxt;
  logic               odir_r;
  logic               busy_r;
  status_t            status_r, status_nxt;
  logic               done_r, done_nxt;

  logic               fire;
  logic               is_move;
  logic               busy;
  logic [11:0]        pos_goal_w;
  logic               pos_bad;
  logic [17:0]        force_w;
  logic [CNT_W-1:0]   force_goal;
  logic               move_ok;
  logic               stop;
  logic [RATIO_W:0]   ratio_sum;
  logic [RATIO_W:0]   drive_sum;
  logic               can_boost;

  assign adv  = !out_valid_r || out_ch.ready;
  assign fire = s1_valid && adv;

  // shared decode
  always_comb begin
    is_move    = !s1.command;
    busy       = (phase_r != PH_IDLE);
    pos_goal_w = {1'b0, s1.pos_q} + 12'(cfg.pos_min);
    pos_bad    = pos_goal_w > 12'(cfg.pos_max);
    if (s1.force_q == '0) begin
      force_w = 18'(cfg.force_thr);
    end else begin
      force_w = 18'(s1.force_q) + 18'(cfg.force_ofs);
    end
    force_goal = (force_w > 18'(cfg.max_force)) ? cfg.max_force : force_w[CNT_W-1:0];
    move_ok    = is_move && !busy && !s1.negative && !pos_bad;
    if (dir_r) begin
      stop = (s1.force_smp >= goal_force_r) || (s1.pos_smp <= goal_pos_r);
    end else begin
      stop = (s1.pos_smp >= goal_pos_r);
    end
    ratio_sum = {1'b0, cfg.jog} + {1'b0, boost_r};
    can_boost = (ratio_sum < (RATIO_W + 1)'(RATIO_LIMIT)) &&
                (s1.force_smp > cfg.force_thr) && (s1.force_smp < cfg.max_force);
  end

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    goal_pos_nxt   = goal_pos_r;
    goal_force_nxt = goal_force_r;
    boost_nxt      = boost_r;
    timer_nxt      = timer_r;
    last_pos_nxt   = last_pos_r;
    last_force_nxt = last_force_r;
    dir_nxt        = dir_r;
    if (fire) begin
      if (is_move) begin
        if (move_ok) begin
          goal_pos_nxt   = pos_goal_w[CNT_W-1:0];
          goal_force_nxt = force_goal;
          dir_nxt        = (pos_goal_w[CNT_W-1:0] < last_pos_r);
          boost_nxt      = '0;
          timer_nxt      = '0;
          phase_nxt      = PH_ARMED;
        end
      end else begin
        last_pos_nxt   = s1.pos_smp;
        last_force_nxt = s1.force_smp;
        if (busy) begin
          if (stop) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_MOVING;
            if (dir_r) begin
              if (timer_r != '0) begin
                timer_nxt = timer_r - 1'b1;
              end else if (can_boost) begin
                boost_nxt = boost_r + 1'b1;
                timer_nxt = TIMER_W'(RAMP_TICKS - 1);
              end
            end
          end
        end
      end
    end
  end

  // result fields
  always_comb begin
    drive_sum = {1'b0, cfg.jog} + {1'b0, boost_nxt};
    if (phase_nxt != PH_MOVING) begin
      ratio_nxt = '0;
    end else if (dir_nxt) begin
      ratio_nxt = drive_sum[RATIO_W-1:0];
    end else begin
      ratio_nxt = cfg.jog;
    end
    status_nxt = ST_OK;
    if (is_move) begin
      if (busy) begin
        status_nxt = ST_BUSY;
      end else if (s1.negative) begin
        status_nxt = ST_NEG;
      end else if (pos_bad) begin
        status_nxt = ST_BAD_POS;
      end
    end
    done_nxt = !is_move && busy && stop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      goal_pos_r   <= '0;
      goal_force_r <= '0;
      boost_r      <= '0;
      timer_r      <= '0;
      last_pos_r   <= '0;
      last_force_r <= '0;
      dir_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      goal_pos_r   <= goal_pos_nxt;
      goal_force_r <= goal_force_nxt;
      boost_r      <= boost_nxt;
      timer_r      <= timer_nxt;
      last_pos_r   <= last_pos_nxt;
      last_force_r <= last_force_nxt;
      dir_r        <= dir_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ratio_r  <= ratio_nxt;
      odir_r   <= dir_nxt;
      busy_r   <= (phase_nxt != PH_IDLE);
      status_r <= status_nxt;
      done_r   <= done_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.motor_ratio  = ratio_r;
  assign out_ch.direction_in = odir_r;
  assign out_ch.busy_res     = busy_r;
  assign out_ch.status       = status_r;
  assign out_ch.done_res     = done_r;

endmodule

FILE: src/gripper_move_controller_core.sv
`timescale 1ns / 1ps

// Gripper move controller. Takes one item (move command or sample tick) per clock
// while the output side is not stalled, and returns exactly one result item per
// input item, which passes the first stage register and then the output register.
// The first stage scales the move targets to ADC counts with two small multipliers
// (11x16 and 15x10 magnitude bits) and registers the products; the second stage
// range-checks the goals, runs the idle/armed/moving sequence and the PWM ramp, and
// loads the output register. Input ready follows the output side, so a stalled result
// holds at most the two stage registers before input ready drops.

module gripper_move_controller_core
  import gmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  gmc_in_if.sink    in_ch,
  gmc_out_if.source out_ch,
  gmc_cfg_if.sink   cfg_ch
);

  cfg_t cfg;
  logic adv;
  logic s1_valid;
  s1_t  s1;

  gmc_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  gmc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  gmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .cfg      (cfg),
    .adv      (adv),
    .out_ch   (out_ch)
  );

  a_idle_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.busy_res || out_ch.motor_ratio == '0))
    else $error("motor driven while not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.done_res) |->
      (!out_ch.busy_res && out_ch.status == ST_OK && out_ch.motor_ratio == '0))
    else $error("done item not idle");

  a_refuse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_BUSY) |-> (out_ch.busy_res && !out_ch.done_res))
    else $error("busy refusal while idle");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> ##2 out_ch.valid)
    else $error("accepted item produced no result");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gmc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 190;
  localparam int NUM_PHASES   = 8;
  localparam int MAX_REPORTS  = 40;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic        command;
    logic [11:0] mm;
    logic [15:0] kg;
    logic [7:0]  frc;
    logic [7:0]  pos;
  } grip_item_t;

  typedef struct packed {
    logic [4:0] ratio;
    logic       dir;
    logic       busy;
    status_t    st;
    logic       done;
  } grip_result_t;

  typedef enum {CFG_RESETVAL, CFG_TYPICAL, CFG_MINIMUM, CFG_MAXIMUM, CFG_ANY} cfg_kind_t;

  function automatic cfg_t pick_config(cfg_kind_t k);
    cfg_t c;
    case (k)
      CFG_RESETVAL: begin
        c.pos_cpm   = RST_POS_CPM;
        c.force_cpk = RST_FORCE_CPK;
        c.pos_min   = RST_POS_MIN;
        c.pos_max   = RST_POS_MAX;
        c.force_ofs = RST_FORCE_OFS;
        c.force_thr = RST_FORCE_THR;
        c.max_force = RST_MAX_FORCE;
        c.jog       = RST_JOG;
      end
      CFG_MINIMUM: c = '0;
      CFG_MAXIMUM: c = '1;
      CFG_TYPICAL: begin
        c.pos_cpm   = 16'($urandom_range(4000, 20000));
        c.force_cpk = 10'($urandom_range(20, 300));
        c.pos_min   = 8'($urandom_range(0, 60));
        c.pos_max   = 8'($urandom_range(120, 255));
        c.force_ofs = 8'($urandom_range(0, 20));
        c.force_thr = 8'(c.force_ofs + $urandom_range(0, 20));
        c.max_force = 8'($urandom_range(180, 255));
        c.jog       = 5'($urandom_range(10, 20));
      end
      default: begin
        c.pos_cpm   = 16'($urandom);
        c.force_cpk = 10'($urandom);
        c.pos_min   = 8'($urandom);
        c.pos_max   = 8'($urandom);
        c.force_ofs = 8'($urandom);
        c.force_thr = 8'($urandom);
        c.max_force = 8'($urandom);
        c.jog       = 5'($urandom);
      end
    endcase
    return c;
  endfunction

  class gripper_drive_model;
    cfg_t         regs;
    phase_t       ph;
    logic [7:0]   goal_pos, goal_frc, pos_now, frc_now;
    logic [4:0]   boost;
    logic [5:0]   ramp;
    logic         dir_in;
    grip_result_t expected_drive[$];
    int           mismatches, moves, refused, stops, peak_boost;

    function new();
      regs = pick_config(CFG_RESETVAL);
      ph = PH_IDLE;
      goal_pos = '0;
      goal_frc = '0;
      pos_now = '0;
      frc_now = '0;
      boost = '0;
      ramp = '0;
      dir_in = 1'b0;
      mismatches = 0;
      moves = 0;
      refused = 0;
      stops = 0;
      peak_boost = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [15:0] v);
      case (r)
        REG_POS_CPM:   regs.pos_cpm   = v;
        REG_FORCE_CPK: regs.force_cpk = v[9:0];
        REG_POS_MIN:   regs.pos_min   = v[7:0];
        REG_POS_MAX:   regs.pos_max   = v[7:0];
        REG_FORCE_OFS: regs.force_ofs = v[7:0];
        REG_FORCE_THR: regs.force_thr = v[7:0];
        REG_MAX_FORCE: regs.max_force = v[7:0];
        REG_JOG:       regs.jog       = v[4:0];
        default: ;
      endcase
    endfunction

    function int pos_goal(logic [11:0] mm);
      return ((int'(mm[10:0]) * int'(regs.pos_cpm)) >>> 16) + int'(regs.pos_min);
    endfunction

    function logic [4:0] drive_now();
      if (ph != PH_MOVING) return 5'd0;
      if (dir_in) return regs.jog + boost;
      return regs.jog;
    endfunction

    function void queue_drive(logic [4:0] ratio, status_t st, logic done);
      grip_result_t r;
      r.ratio = ratio;
      r.dir   = dir_in;
      r.busy  = (ph != PH_IDLE);
      r.st    = st;
      r.done  = done;
      if (st != ST_OK) refused++;
      expected_drive.push_back(r);
    endfunction

    function void take_item(grip_item_t it);
      int gp, gf;
      if (it.command == CMD_MOVE) begin
        if (ph != PH_IDLE) begin
          queue_drive(drive_now(), ST_BUSY, 1'b0);
          return;
        end
        if (it.mm[11] || it.kg[15]) begin
          queue_drive(5'd0, ST_NEG, 1'b0);
          return;
        end
        gp = pos_goal(it.mm);
        if (gp > int'(regs.pos_max)) begin
          queue_drive(5'd0, ST_BAD_POS, 1'b0);
          return;
        end
        gf = ((int'(it.kg[14:0]) * int'(regs.force_cpk)) >>> 8) + int'(regs.force_ofs);
        if (gf == int'(regs.force_ofs)) gf = int'(regs.force_thr);
        if (gf > int'(regs.max_force)) gf = int'(regs.max_force);
        goal_pos = gp[7:0];
        goal_frc = gf[7:0];
        dir_in = (goal_pos < pos_now);
        boost = '0;
        ramp = '0;
        ph = PH_ARMED;
        moves++;
        queue_drive(5'd0, ST_OK, 1'b0);
        return;
      end
      frc_now = it.frc;
      pos_now = it.pos;
      if (ph == PH_IDLE) begin
        queue_drive(5'd0, ST_OK, 1'b0);
        return;
      end
      if (dir_in ? (frc_now >= goal_frc || pos_now <= goal_pos) : (pos_now >= goal_pos)) begin
        ph = PH_IDLE;
        stops++;
        queue_drive(5'd0, ST_OK, 1'b1);
        return;
      end
      if (dir_in) begin
        if (ramp != 0) begin
          ramp = ramp - 1'b1;
        end else if (int'(regs.jog) + int'(boost) < RATIO_LIMIT &&
                     frc_now > regs.force_thr && frc_now < regs.max_force) begin
          boost = boost + 1'b1;
          ramp = 6'(RAMP_TICKS - 1);
          if (int'(boost) > peak_boost) peak_boost = int'(boost);
        end
      end
      ph = PH_MOVING;
      queue_drive(drive_now(), ST_OK, 1'b0);
    endfunction

    function void cmp_field(string what, logic [4:0] want, logic [4:0] seen);
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
      end
    endfunction

    function void check_drive(grip_result_t got);
      grip_result_t want;
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_drive.pop_front();
      cmp_field("motor_ratio", want.ratio, got.ratio);
      cmp_field("direction_in", want.dir, got.dir);
      cmp_field("busy_res", want.busy, got.busy);
      cmp_field("status", want.st, got.st);
      cmp_field("done_res", want.done, got.done);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  gmc_in_if  in_ch();
  gmc_out_if out_ch();
  gmc_cfg_if cfg_ch();

  gripper_move_controller_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  gripper_drive_model grip = new();

  cfg_kind_t plan [NUM_PHASES] = '{CFG_RESETVAL, CFG_TYPICAL, CFG_MINIMUM, CFG_TYPICAL,
                                   CFG_MAXIMUM, CFG_ANY, CFG_TYPICAL, CFG_RESETVAL};

  int n_sent = 0;
  int cycles = 0;
  int stall_left = 0;
  bit in_gaps = 1'b0;
  bit out_stalls = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycles,
               grip.expected_drive.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : out_side
    grip_result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.ratio = out_ch.motor_ratio;
      got.dir   = out_ch.direction_in;
      got.busy  = out_ch.busy_res;
      got.st    = status_t'(out_ch.status);
      got.done  = out_ch.done_res;
      grip.check_drive(got);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= (stall_left == 0);
    end else if (out_stalls && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send(grip_item_t it);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      in_ch.target_mm <= 12'($urandom);
      in_ch.target_kg <= 16'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.command         <= it.command;
    in_ch.target_mm       <= it.mm;
    in_ch.target_kg       <= it.kg;
    in_ch.force_sample    <= it.frc;
    in_ch.position_sample <= it.pos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    grip.take_item(it);
    n_sent++;
  endtask

  task automatic move(logic [11:0] mm, logic [15:0] kg);
    grip_item_t it;
    it.command = CMD_MOVE;
    it.mm = mm;
    it.kg = kg;
    it.frc = 8'($urandom);
    it.pos = 8'($urandom);
    send(it);
  endtask

  task automatic tick(logic [7:0] frc, logic [7:0] pos);
    grip_item_t it;
    it.command = CMD_TICK;
    it.mm = 12'($urandom);
    it.kg = 16'($urandom);
    it.frc = frc;
    it.pos = pos;
    send(it);
  endtask

  // let every queued result come back before touching the registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (grip.expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t r, logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    grip.set_reg(r, v);
  endtask

  // unused upper data bits carry noise
  task automatic apply_config(cfg_t c);
    set_reg(REG_POS_CPM, c.pos_cpm);
    set_reg(REG_FORCE_CPK, {6'($urandom), c.force_cpk});
    set_reg(REG_POS_MIN, {8'($urandom), c.pos_min});
    set_reg(REG_POS_MAX, {8'($urandom), c.pos_max});
    set_reg(REG_FORCE_OFS, {8'($urandom), c.force_ofs});
    set_reg(REG_FORCE_THR, {8'($urandom), c.force_thr});
    set_reg(REG_MAX_FORCE, {8'($urandom), c.max_force});
    set_reg(REG_JOG, {11'($urandom), c.jog});
    cfg_ch.valid <= 1'b0;
  endtask

  // sample, move, then a run of ticks that creeps toward the goal
  task automatic run_motion();
    logic [7:0]  pos;
    logic [11:0] mm;
    logic [15:0] kg;
    int n, lo, hi;
    pos = 8'($urandom);
    tick(8'($urandom), pos);
    if ($urandom_range(0, 9) == 0) begin
      move(12'($urandom), 16'($urandom));
    end else begin
      mm = 12'($urandom_range(0, 2047));
      while (mm != 0 && grip.pos_goal(mm) > int'(grip.regs.pos_max)) mm = mm >> 1;
      kg = ($urandom_range(0, 3) == 0) ? 16'd0 :
           16'($urandom_range(0, 32767) >> $urandom_range(0, 14));
      move(mm, kg);
    end
    if (grip.ph == PH_IDLE) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 320) : $urandom_range(1, 40);
    repeat (n) begin
      if (grip.ph == PH_IDLE) break;
      if ($urandom_range(0, 39) == 0) begin
        move(12'($urandom), 16'($urandom));
        continue;
      end
      if ($urandom_range(0, 24) == 0) begin
        tick(8'($urandom), 8'($urandom));
        continue;
      end
      if ($urandom_range(0, 7) == 0) begin
        if (grip.dir_in && int'(pos) > int'(grip.goal_pos) + 1) pos = pos - 1'b1;
        else if (!grip.dir_in && int'(pos) + 1 < int'(grip.goal_pos)) pos = pos + 1'b1;
      end
      lo = int'(grip.regs.force_thr) + 1;
      hi = int'(grip.regs.max_force) - 1;
      if (grip.dir_in && int'(grip.goal_frc) - 1 < hi) hi = int'(grip.goal_frc) - 1;
      if (lo <= hi) tick(8'($urandom_range(lo, hi)), pos);
      else tick(8'($urandom), pos);
    end
    if (grip.ph != PH_IDLE && $urandom_range(0, 3) != 0) tick(8'($urandom), grip.goal_pos);
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_MOVE;
    in_ch.target_mm = '0;
    in_ch.target_kg = '0;
    in_ch.force_sample = '0;
    in_ch.position_sample = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_POS_CPM;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gaps = 1'b1;
    out_stalls = 1'b1;
    tick(8'd0, 8'd200);
    move(12'hFFF, 16'd0);
    move(12'd0, 16'h8000);
    move(12'h7FF, 16'h7FFF);
    move(12'd0, 16'd0);       // zero force maps to the threshold
    move(12'd0, 16'd0);       // busy while armed
    tick(8'd10, 8'd150);
    move(12'd0, 16'd0);       // busy while moving
    tick(8'd14, 8'd100);
    tick(8'd15, 8'd100);
    move(12'd400, 16'h7FFF);  // force target saturates
    tick(8'd100, 8'd120);
    tick(8'd255, 8'd90);
    tick(8'd0, 8'd30);
    move(12'd800, 16'd256);   // outward
    tick(8'd250, 8'd100);
    tick(8'd0, 8'd149);
    move(12'd0, 16'd0);
    tick(8'd0, 8'd27);
    tick(8'hFF, 8'hFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        drain();
        apply_config(pick_config(plan[p]));
      end
      in_gaps = (p % 3 != 2) && (p != NUM_PHASES - 1);
      out_stalls = (p % 3 != 1) && (p != NUM_PHASES - 1);
      target = n_sent + PHASE_ITEMS;
      while (n_sent < target) run_motion();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Ran %0d items over %0d register settings: %0d moves started, %0d refused,",
             n_sent, NUM_PHASES, grip.moves, grip.refused);
    $display("%0d motion stops, inward ramp boost reached %0d.", grip.stops, grip.peak_boost);
    if (grip.mismatches == 0 && grip.expected_drive.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
